### src/tafg_pkg.sv
`default_nettype none
package tafg_pkg;

  // sizes of the motor and servo banks
  localparam int unsigned MOTOR_COUNT = 9;
  localparam int unsigned SERVO_COUNT = 4;
  // motor width fields carried by one input item
  localparam int unsigned MAX_MOTORS  = 9;

  localparam int unsigned PULSE_W     = 12;
  localparam int unsigned BURST_LEN   = MOTOR_COUNT + SERVO_COUNT;
  localparam int unsigned BURST_IDX_W = (BURST_LEN > 1) ? $clog2(BURST_LEN) : 1;
  localparam int unsigned SERVO_IDX_W = (SERVO_COUNT > 1) ? $clog2(SERVO_COUNT) : 1;

  localparam int unsigned APB_ADDR_W  = 5;
  localparam int unsigned APB_DATA_W  = 32;

  // reset values
  localparam logic [PULSE_W-1:0] RST_MOTOR_MIN     = 12'd1100;
  localparam logic [PULSE_W-1:0] RST_MOTOR_MAX     = 12'd1900;
  localparam logic [PULSE_W-1:0] RST_MOTOR_NEUTRAL = 12'd1500;
  localparam logic [PULSE_W-1:0] RST_SERVO_MIN     = 12'd1100;
  localparam logic [PULSE_W-1:0] RST_SERVO_MAX     = 12'd1900;
  localparam logic [PULSE_W-1:0] RST_SERVO_PULSE   = 12'd1500;
  localparam logic [15:0]        RST_SILENCE_LIMIT = 16'd1000;
  localparam logic [3:0]         RST_MOTOR_BASE    = 4'd0;
  localparam logic [3:0]         RST_SERVO_BASE    = 4'd9;

  // command codes
  typedef enum logic [2:0] {
    FUNC_OVERRIDE  = 3'd0,
    FUNC_ARM       = 3'd1,
    FUNC_SET_SERVO = 3'd2,
    FUNC_TICK      = 3'd3,
    FUNC_EMIT      = 3'd4
  } func_e;

  // register indexes on the configuration port
  typedef enum logic [2:0] {
    REG_MOTOR_MIN     = 3'd0,
    REG_MOTOR_MAX     = 3'd1,
    REG_MOTOR_NEUTRAL = 3'd2,
    REG_SERVO_MIN     = 3'd3,
    REG_SERVO_MAX     = 3'd4,
    REG_SILENCE_LIMIT = 3'd5,
    REG_MOTOR_BASE    = 3'd6,
    REG_SERVO_BASE    = 3'd7
  } reg_idx_e;

  typedef struct packed {
    logic [2:0]         func;
    logic [15:0]        pulse_a;
    logic [15:0]        pulse_b;
    logic [15:0]        pulse_c;
    logic [15:0]        pulse_d;
    logic [15:0]        pulse_e;
    logic [15:0]        pulse_f;
    logic [15:0]        pulse_g;
    logic [15:0]        pulse_h;
    logic [15:0]        pulse_i;
    logic signed [15:0] argument;
    logic [31:0]        now_ms;
  } in_item_t;

  typedef struct packed {
    logic         is_write;
    logic [4:0]   channel;
    logic [11:0]  pulse;
    logic         accepted;
    logic         armed_now;
    logic         last;
  } out_item_t;

  // per-lane update controls
  typedef struct packed {
    logic write;
    logic stop;
  } lane_ctrl_t;

  // motor limits shared by every lane
  typedef struct packed {
    logic [PULSE_W-1:0] pmin;
    logic [PULSE_W-1:0] pmax;
    logic [PULSE_W-1:0] neutral;
  } motor_cfg_t;

  // one pending job for the result sequencer
  typedef struct packed {
    logic                              burst;
    logic                              accepted;
    logic                              armed_now;
    logic [BURST_LEN-1:0][PULSE_W-1:0] pulses;
  } job_t;

endpackage
`default_nettype wire

### src/thruster_arming_failsafe_guard.sv
`default_nettype none
// Thruster arming failsafe guard. Keeps nine motor widths, four servo widths and an
// armed flag, and checks every command against the limits set over the APB port.
// Override, arm, set-servo, tick and unknown commands each give one status result;
// disarm and emit give thirteen channel writes (motors first, then servos), the last
// one flagged. Each motor has its own check lane and a merge stage picks the prefix
// of motors that take their new widths. An item is executed in the cycle it is
// accepted; its results pass through a job slot and leave one per cycle, unless
// the output stalls, from a single output register. Status items can thus follow
// one another every cycle, a disarm or emit holds the sequencer until its thirteen
// writes have left, and the input is stalled only while that job slot is occupied.
module thruster_arming_failsafe_guard
  import tafg_pkg::*;
(
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  // command transfer
  input  wire logic                  in_valid_i,
  output logic                       in_stall_o,
  input  wire in_item_t              in_item_i,
  // result transfer
  output logic                       out_valid_o,
  input  wire logic                  out_stall_i,
  output out_item_t                  out_item_o,
  // configuration port
  input  wire logic                  psel,
  input  wire logic                  penable,
  input  wire logic                  pwrite,
  input  wire logic [APB_ADDR_W-1:0] paddr,
  input  wire logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0]      prdata,
  output logic                       pready
);

  // configuration registers
  logic [PULSE_W-1:0] motor_min_q, motor_max_q, motor_neutral_q;
  logic [PULSE_W-1:0] servo_min_q, servo_max_q;
  logic [15:0]        silence_q;
  logic [3:0]         motor_base_q, servo_base_q;

  logic     cfg_wr;
  reg_idx_e cfg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_idx = reg_idx_e'(paddr[4:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      motor_min_q     <= RST_MOTOR_MIN;
      motor_max_q     <= RST_MOTOR_MAX;
      motor_neutral_q <= RST_MOTOR_NEUTRAL;
      servo_min_q     <= RST_SERVO_MIN;
      servo_max_q     <= RST_SERVO_MAX;
      silence_q       <= RST_SILENCE_LIMIT;
      motor_base_q    <= RST_MOTOR_BASE;
      servo_base_q    <= RST_SERVO_BASE;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_MOTOR_MIN:     motor_min_q     <= pwdata[PULSE_W-1:0];
        REG_MOTOR_MAX:     motor_max_q     <= pwdata[PULSE_W-1:0];
        REG_MOTOR_NEUTRAL: motor_neutral_q <= pwdata[PULSE_W-1:0];
        REG_SERVO_MIN:     servo_min_q     <= pwdata[PULSE_W-1:0];
        REG_SERVO_MAX:     servo_max_q     <= pwdata[PULSE_W-1:0];
        REG_SILENCE_LIMIT: silence_q       <= pwdata[15:0];
        REG_MOTOR_BASE:    motor_base_q    <= pwdata[3:0];
        REG_SERVO_BASE:    servo_base_q    <= pwdata[3:0];
        default: ;
      endcase
    end
  end

  // register readback
  always_comb begin
    case (cfg_idx)
      REG_MOTOR_MIN:     prdata = APB_DATA_W'(motor_min_q);
      REG_MOTOR_MAX:     prdata = APB_DATA_W'(motor_max_q);
      REG_MOTOR_NEUTRAL: prdata = APB_DATA_W'(motor_neutral_q);
      REG_SERVO_MIN:     prdata = APB_DATA_W'(servo_min_q);
      REG_SERVO_MAX:     prdata = APB_DATA_W'(servo_max_q);
      REG_SILENCE_LIMIT: prdata = APB_DATA_W'(silence_q);
      REG_MOTOR_BASE:    prdata = APB_DATA_W'(motor_base_q);
      REG_SERVO_BASE:    prdata = APB_DATA_W'(servo_base_q);
      default:           prdata = '0;
    endcase
  end

  // command state
  logic               armed_q, armed_d;
  logic [31:0]        last_ms_q, last_ms_d;
  logic [PULSE_W-1:0] servo_q [SERVO_COUNT];

  logic accept;
  assign accept = in_valid_i && !in_stall_o;

  // requested widths per motor
  logic [15:0] req [MAX_MOTORS];
  assign req[0] = in_item_i.pulse_a;
  assign req[1] = in_item_i.pulse_b;
  assign req[2] = in_item_i.pulse_c;
  assign req[3] = in_item_i.pulse_d;
  assign req[4] = in_item_i.pulse_e;
  assign req[5] = in_item_i.pulse_f;
  assign req[6] = in_item_i.pulse_g;
  assign req[7] = in_item_i.pulse_h;
  assign req[8] = in_item_i.pulse_i;

  motor_cfg_t motor_cfg;
  assign motor_cfg.pmin    = motor_min_q;
  assign motor_cfg.pmax    = motor_max_q;
  assign motor_cfg.neutral = motor_neutral_q;

  logic [MOTOR_COUNT-1:0] pass, live, commit;
  logic                   all_ok, any_live;
  logic [PULSE_W-1:0]     motor_next [MOTOR_COUNT];
  lane_ctrl_t             lane_ctrl [MOTOR_COUNT];

  logic is_override, stop_all;

  // motor lanes
  for (genvar g = 0; g < MOTOR_COUNT; g++) begin : g_lane
    assign lane_ctrl[g].write = accept && is_override && commit[g];
    assign lane_ctrl[g].stop  = accept && stop_all;

    tafg_lane u_lane (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .cfg_i     (motor_cfg),
      .armed_i   (armed_q),
      .req_i     (req[g]),
      .ctrl_i    (lane_ctrl[g]),
      .pass_o    (pass[g]),
      .live_o    (live[g]),
      .pulse_d_o (motor_next[g])
    );
  end

  tafg_merge u_merge (
    .pass_i     (pass),
    .live_i     (live),
    .commit_o   (commit),
    .all_ok_o   (all_ok),
    .any_live_o (any_live)
  );

  // decode and execute the command
  func_e       func;
  logic        arm_req;
  logic        servo_idx_ok, servo_ok, servo_wr;
  logic        clk_wrap, silent;
  logic [31:0] gap;
  logic        burst, status_acc;

  assign func         = func_e'(in_item_i.func);
  assign is_override  = (func == FUNC_OVERRIDE);
  assign arm_req      = !in_item_i.argument[15] && (in_item_i.argument != '0);
  assign servo_idx_ok = !in_item_i.argument[15] &&
                        ($unsigned(in_item_i.argument) < 16'(SERVO_COUNT));
  assign servo_ok     = servo_idx_ok &&
                        (in_item_i.pulse_a >= {4'd0, servo_min_q}) &&
                        (in_item_i.pulse_a <= {4'd0, servo_max_q});
  assign servo_wr     = accept && (func == FUNC_SET_SERVO) && servo_ok;
  assign clk_wrap     = in_item_i.now_ms < last_ms_q;
  assign gap          = in_item_i.now_ms - last_ms_q;
  assign silent       = gap > {16'd0, silence_q};

  always_comb begin
    armed_d    = armed_q;
    last_ms_d  = last_ms_q;
    stop_all   = 1'b0;
    burst      = 1'b0;
    status_acc = 1'b0;
    case (func)
      FUNC_OVERRIDE: begin
        status_acc = all_ok;
        if (all_ok) begin
          last_ms_d = in_item_i.now_ms;
        end
      end
      FUNC_ARM: begin
        if (arm_req) begin
          armed_d    = 1'b1;
          status_acc = 1'b1;
        end else begin
          armed_d  = 1'b0;
          stop_all = 1'b1;
          burst    = 1'b1;
        end
      end
      FUNC_SET_SERVO: status_acc = servo_ok;
      FUNC_TICK: begin
        status_acc = 1'b1;
        if (clk_wrap) begin
          last_ms_d = in_item_i.now_ms;
          stop_all  = 1'b1;
        end else if (silent) begin
          stop_all = 1'b1;
          if (any_live) begin
            last_ms_d = in_item_i.now_ms;
          end
        end
      end
      FUNC_EMIT: burst = 1'b1;
      default: status_acc = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      armed_q   <= 1'b0;
      last_ms_q <= '0;
      for (int i = 0; i < SERVO_COUNT; i++) begin
        servo_q[i] <= RST_SERVO_PULSE;
      end
    end else begin
      if (accept) begin
        armed_q   <= armed_d;
        last_ms_q <= last_ms_d;
      end
      if (servo_wr) begin
        servo_q[in_item_i.argument[SERVO_IDX_W-1:0]] <= in_item_i.pulse_a[PULSE_W-1:0];
      end
    end
  end

  // job for the result sequencer, widths taken after this command
  job_t job;
  always_comb begin
    job.burst     = burst;
    job.accepted  = status_acc;
    job.armed_now = armed_d;
    for (int i = 0; i < MOTOR_COUNT; i++) begin
      job.pulses[i] = motor_next[i];
    end
    for (int i = 0; i < SERVO_COUNT; i++) begin
      job.pulses[MOTOR_COUNT + i] = servo_q[i];
    end
  end

  tafg_seq u_seq (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .load_i       (accept),
    .job_i        (job),
    .motor_base_i (motor_base_q),
    .servo_base_i (servo_base_q),
    .busy_o       (in_stall_o),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_item_o   (out_item_o)
  );

endmodule
`default_nettype wire

### src/tafg_lane.sv
`default_nettype none
module tafg_lane
  import tafg_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire motor_cfg_t         cfg_i,
  input  wire logic               armed_i,
  input  wire logic [15:0]        req_i,
  input  wire lane_ctrl_t         ctrl_i,
  output logic                    pass_o,
  output logic                    live_o,
  output logic [PULSE_W-1:0]      pulse_d_o
);

  logic [PULSE_W-1:0] pulse_q;
  logic               in_range;
  logic               is_neutral;

  // width check for this motor
  assign in_range   = (req_i >= {4'd0, cfg_i.pmin}) && (req_i <= {4'd0, cfg_i.pmax});
  assign is_neutral = (req_i == {4'd0, cfg_i.neutral});
  assign pass_o     = in_range && (armed_i || is_neutral);

  // stored width differs from neutral
  assign live_o = (pulse_q != cfg_i.neutral);

  // next stored width
  always_comb begin
    if (ctrl_i.stop) begin
      pulse_d_o = cfg_i.neutral;
    end else if (ctrl_i.write) begin
      pulse_d_o = req_i[PULSE_W-1:0];
    end else begin
      pulse_d_o = pulse_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pulse_q <= RST_MOTOR_NEUTRAL;
    end else begin
      pulse_q <= pulse_d_o;
    end
  end

endmodule
`default_nettype wire

### src/tafg_merge.sv
`default_nettype none
module tafg_merge
  import tafg_pkg::*;
(
  input  wire logic [MOTOR_COUNT-1:0] pass_i,
  input  wire logic [MOTOR_COUNT-1:0] live_i,
  output logic [MOTOR_COUNT-1:0]      commit_o,
  output logic                        all_ok_o,
  output logic                        any_live_o
);

  // a motor takes its new width only if it and every earlier one passed
  always_comb begin
    logic run;
    run = 1'b1;
    for (int i = 0; i < MOTOR_COUNT; i++) begin
      run         = run & pass_i[i];
      commit_o[i] = run;
    end
  end

  assign all_ok_o   = &pass_i;
  assign any_live_o = |live_i;

endmodule
`default_nettype wire

### src/tafg_seq.sv
`default_nettype none
module tafg_seq
  import tafg_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       load_i,
  input  wire job_t       job_i,
  input  wire logic [3:0] motor_base_i,
  input  wire logic [3:0] servo_base_i,
  output logic            busy_o,
  output logic            out_valid_o,
  input  wire logic       out_stall_i,
  output out_item_t       out_item_o
);

  logic                   job_valid_q, job_valid_d;
  job_t                   job_q;
  logic [BURST_IDX_W-1:0] idx_q, idx_d;
  logic                   out_valid_q, out_valid_d;
  out_item_t              out_q, out_d;

  logic out_free;
  logic emit;
  logic last_res;
  logic job_done;

  assign out_free = !out_valid_q || !out_stall_i;
  assign emit     = job_valid_q && out_free;
  assign last_res = !job_q.burst || (idx_q == BURST_IDX_W'(BURST_LEN - 1));
  assign job_done = emit && last_res;
  assign busy_o   = job_valid_q && !job_done;

  // job slot and burst position
  always_comb begin
    job_valid_d = job_valid_q;
    idx_d       = idx_q;
    if (emit) begin
      idx_d = last_res ? '0 : idx_q + 1'b1;
    end
    if (load_i) begin
      job_valid_d = 1'b1;
    end else if (job_done) begin
      job_valid_d = 1'b0;
    end
  end

  // build the next result
  always_comb begin
    out_valid_d = out_valid_q;
    out_d       = out_q;
    if (emit) begin
      out_valid_d     = 1'b1;
      out_d.armed_now = job_q.armed_now;
      out_d.last      = last_res;
      if (job_q.burst) begin
        out_d.is_write = 1'b1;
        out_d.accepted = 1'b1;
        out_d.pulse    = job_q.pulses[idx_q];
        if (idx_q < BURST_IDX_W'(MOTOR_COUNT)) begin
          out_d.channel = {1'b0, motor_base_i} + 5'(idx_q);
        end else begin
          out_d.channel = {1'b0, servo_base_i} + 5'(idx_q - BURST_IDX_W'(MOTOR_COUNT));
        end
      end else begin
        out_d.is_write = 1'b0;
        out_d.accepted = job_q.accepted;
        out_d.pulse    = '0;
        out_d.channel  = '0;
      end
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      job_valid_q <= 1'b0;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      job_valid_q <= job_valid_d;
      idx_q       <= idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (load_i) begin
      job_q <= job_i;
    end
    out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

endmodule
`default_nettype wire

### tb/sv/tb_thruster_arming_failsafe_guard.sv
`default_nettype none
module tb_thruster_arming_failsafe_guard;
  import tafg_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  // func codes the block does not define
  localparam logic [2:0] FUNC_SPARE_FIRST = 3'd5;
  localparam logic [2:0] FUNC_SPARE_LAST  = 3'd7;
  // quiet cycles with work outstanding before the run is abandoned
  localparam int unsigned STALL_LIMIT = 2000;
  localparam int unsigned PHASES      = 6;
  localparam int unsigned CHUNK_ITEMS = 36;

  logic                  clk_i      = 1'b0;
  logic                  rst_ni     = 1'b0;
  logic                  in_valid_i = 1'b0;
  logic                  in_stall_o;
  in_item_t              in_item_i  = '0;
  logic                  out_valid_o;
  logic                  out_stall_i = 1'b0;
  out_item_t             out_item_o;
  logic                  psel    = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite  = 1'b0;
  logic [APB_ADDR_W-1:0] paddr   = '0;
  logic [APB_DATA_W-1:0] pwdata  = '0;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;

  thruster_arming_failsafe_guard i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_item_i   (in_item_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  // clock
  initial begin
    forever #6 clk_i = ~clk_i;
  end

  // commands waiting for the driver, results waiting for the block
  in_item_t  cmd_q[$];
  out_item_t guard_result_q[$];

  // shadow of the block's registers
  logic [11:0] cfg_mmin    = RST_MOTOR_MIN;
  logic [11:0] cfg_mmax    = RST_MOTOR_MAX;
  logic [11:0] cfg_neutral = RST_MOTOR_NEUTRAL;
  logic [11:0] cfg_smin    = RST_SERVO_MIN;
  logic [11:0] cfg_smax    = RST_SERVO_MAX;
  logic [15:0] cfg_silence = RST_SILENCE_LIMIT;
  logic [3:0]  cfg_mbase   = RST_MOTOR_BASE;
  logic [3:0]  cfg_sbase   = RST_SERVO_BASE;

  // shadow of the guard state
  logic        armed = 1'b0;
  logic [11:0] motor_pw [MOTOR_COUNT];
  logic [11:0] servo_pw [SERVO_COUNT];
  logic [31:0] last_cmd_ms = '0;

  // stimulus bookkeeping
  logic        gen_armed = 1'b0;
  logic [31:0] gen_now   = '0;
  bit          src_idle_on  = 1'b0;
  bit          sink_idle_on = 1'b0;
  int unsigned src_gap  = 0;
  int unsigned sink_gap = 0;
  int unsigned sink_draw = 0;
  int unsigned quiet_cycles = 0;
  int unsigned func_cnt [8];
  int unsigned results_seen = 0;
  int unsigned settings_cnt = 1;
  int unsigned fail_cnt = 0;
  out_item_t   want;

  function automatic int unsigned gap_draw(bit on);
    return on ? $urandom_range(0, 4) : 0;
  endfunction

  // width inside, at or just past the ends of [lo, hi], or random; clean keeps it inside where possible
  function automatic logic [15:0] pick_width(logic [11:0] lo, logic [11:0] hi, bit clean);
    int unsigned r;
    r = $urandom_range(clean ? 12 : 0, 99);
    if (r < 4)  return 16'($urandom);
    if (r < 8)  return {4'h0, lo} - 16'd1;
    if (r < 12) return {4'h0, hi} + 16'd1;
    if (r < 20) return {4'h0, lo};
    if (r < 28) return {4'h0, hi};
    if (lo <= hi) return 16'($urandom_range(lo, hi));
    return 16'($urandom_range(0, 4095));
  endfunction

  function automatic in_item_t pack_override(logic [15:0] pw [MOTOR_COUNT], logic [31:0] now);
    in_item_t it;
    it = '0;
    it.func    = FUNC_OVERRIDE;
    it.pulse_a = pw[0];
    it.pulse_b = pw[1];
    it.pulse_c = pw[2];
    it.pulse_d = pw[3];
    it.pulse_e = pw[4];
    it.pulse_f = pw[5];
    it.pulse_g = pw[6];
    it.pulse_h = pw[7];
    it.pulse_i = pw[8];
    it.now_ms  = now;
    return it;
  endfunction

  // every motor at fill except one (none when odd_idx is out of range)
  function automatic in_item_t override_cmd(logic [15:0] fill, int unsigned odd_idx,
                                            logic [15:0] odd_val, logic [31:0] now);
    logic [15:0] pw [MOTOR_COUNT];
    for (int i = 0; i < MOTOR_COUNT; i++) pw[i] = (i == odd_idx) ? odd_val : fill;
    return pack_override(pw, now);
  endfunction

  function automatic in_item_t plain_cmd(logic [2:0] f, logic [15:0] a, logic [15:0] arg,
                                         logic [31:0] now);
    in_item_t it;
    it = '0;
    it.func     = f;
    it.pulse_a  = a;
    it.argument = arg;
    it.now_ms   = now;
    return it;
  endfunction

  task automatic push_cmd(in_item_t it);
    cmd_q.push_back(it);
    func_cnt[it.func]++;
  endtask

  // predicted results
  task automatic push_status(logic ok);
    guard_result_q.push_back('{is_write: 1'b0, channel: 5'd0, pulse: 12'd0,
                               accepted: ok, armed_now: armed, last: 1'b1});
  endtask

  task automatic push_all_channels();
    for (int i = 0; i < MOTOR_COUNT; i++)
      guard_result_q.push_back('{is_write: 1'b1, channel: 5'(cfg_mbase) + 5'(i),
                                 pulse: motor_pw[i], accepted: 1'b1, armed_now: armed,
                                 last: 1'b0});
    for (int i = 0; i < SERVO_COUNT; i++)
      guard_result_q.push_back('{is_write: 1'b1, channel: 5'(cfg_sbase) + 5'(i),
                                 pulse: servo_pw[i], accepted: 1'b1, armed_now: armed,
                                 last: (i == SERVO_COUNT - 1)});
  endtask

  task automatic stop_motors();
    for (int i = 0; i < MOTOR_COUNT; i++) motor_pw[i] = cfg_neutral;
  endtask

  task automatic guard_predict(in_item_t it);
    logic [15:0] req [MOTOR_COUNT];
    logic        ok;
    logic        moving;
    int unsigned idx;
    req = '{it.pulse_a, it.pulse_b, it.pulse_c, it.pulse_d, it.pulse_e,
            it.pulse_f, it.pulse_g, it.pulse_h, it.pulse_i};
    case (it.func)
      FUNC_OVERRIDE: begin
        // motors take their widths up to the first one that fails
        ok = 1'b1;
        for (int i = 0; i < MOTOR_COUNT; i++) begin
          if (ok && (armed || req[i] == {4'h0, cfg_neutral}) &&
              req[i] >= {4'h0, cfg_mmin} && req[i] <= {4'h0, cfg_mmax})
            motor_pw[i] = req[i][11:0];
          else
            ok = 1'b0;
        end
        if (ok) last_cmd_ms = it.now_ms;
        push_status(ok);
      end
      FUNC_ARM: begin
        if (!it.argument[15] && it.argument != '0) begin
          armed = 1'b1;
          push_status(1'b1);
        end else begin
          stop_motors();
          armed = 1'b0;
          push_all_channels();
        end
      end
      FUNC_SET_SERVO: begin
        ok  = 1'b0;
        idx = it.argument[14:0];
        if (!it.argument[15] && idx < SERVO_COUNT &&
            it.pulse_a >= {4'h0, cfg_smin} && it.pulse_a <= {4'h0, cfg_smax}) begin
          servo_pw[idx] = it.pulse_a[11:0];
          ok = 1'b1;
        end
        push_status(ok);
      end
      FUNC_TICK: begin
        // clock wrap, then silence timeout
        if (it.now_ms < last_cmd_ms) begin
          last_cmd_ms = it.now_ms;
          stop_motors();
        end else if (it.now_ms - last_cmd_ms > {16'h0, cfg_silence}) begin
          moving = 1'b0;
          for (int i = 0; i < MOTOR_COUNT; i++)
            if (motor_pw[i] != cfg_neutral) moving = 1'b1;
          if (moving) last_cmd_ms = it.now_ms;
          stop_motors();
        end
        push_status(1'b1);
      end
      FUNC_EMIT: push_all_channels();
      default: push_status(1'b0);
    endcase
  endtask

  function automatic void check_field(string name, int unsigned exp_v, int unsigned got_v);
    if (exp_v != got_v) begin
      $error("%s: expected %0d, got %0d", name, exp_v, got_v);
      fail_cnt++;
    end
  endfunction

  // random command, mostly well formed for the current arming state
  task automatic push_random_cmd();
    logic [223:0] noise;
    logic [15:0]  pw [MOTOR_COUNT];
    in_item_t     it;
    int unsigned  r;
    bit           clean;
    noise = {$urandom(), $urandom(), $urandom(), $urandom(),
             $urandom(), $urandom(), $urandom()};
    it = noise[$bits(in_item_t)-1:0];
    r  = $urandom_range(0, 99);
    if (r < 40) begin
      clean = $urandom_range(0, 9) < 7;
      for (int i = 0; i < MOTOR_COUNT; i++) begin
        if (gen_armed)
          pw[i] = pick_width(cfg_mmin, cfg_mmax, clean);
        else if (clean || $urandom_range(0, 9) < 7)
          pw[i] = {4'h0, cfg_neutral};
        else
          pw[i] = pick_width(cfg_mmin, cfg_mmax, 1'b0);
      end
      gen_now = gen_now + $urandom_range(0, 300);
      it = pack_override(pw, gen_now);
      it.argument = 16'($urandom);
    end else if (r < 52) begin
      it.func = FUNC_ARM;
      gen_armed = gen_armed ? ($urandom_range(0, 3) == 0) : ($urandom_range(0, 4) != 0);
      if (gen_armed) begin
        case ($urandom_range(0, 3))
          0:       it.argument = 16'd1;
          1:       it.argument = 16'h7fff;
          default: it.argument = 16'($urandom_range(1, 32767));
        endcase
      end else begin
        it.argument = ($urandom_range(0, 1) == 0) ? 16'd0 : {1'b1, 15'($urandom)};
      end
    end else if (r < 65) begin
      it.func    = FUNC_SET_SERVO;
      it.pulse_a = pick_width(cfg_smin, cfg_smax, $urandom_range(0, 3) != 0);
      if ($urandom_range(0, 99) < 85) it.argument = 16'($urandom_range(0, SERVO_COUNT - 1));
    end else if (r < 88) begin
      it.func = FUNC_TICK;
      case ($urandom_range(0, 9))
        8:       gen_now = gen_now - $urandom_range(1, 5000);
        9:       gen_now = $urandom;
        default: gen_now = gen_now + $urandom_range(0, cfg_silence + cfg_silence / 2 + 2);
      endcase
      it.now_ms = gen_now;
    end else if (r < 95) begin
      it.func = FUNC_EMIT;
    end else begin
      it.func = 3'($urandom_range(FUNC_SPARE_FIRST, FUNC_SPARE_LAST));
    end
    push_cmd(it);
  endtask

  // register write followed by a read back
  task automatic cfg_write(reg_idx_e idx, logic [15:0] val);
    logic [31:0] masked;
    case (idx)
      REG_SILENCE_LIMIT:             masked = {16'h0, val};
      REG_MOTOR_BASE, REG_SERVO_BASE: masked = {28'h0, val[3:0]};
      default:                        masked = {20'h0, val[11:0]};
    endcase
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= APB_ADDR_W'({idx, 2'b00});
    pwdata  <= masked;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    pwrite  <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (prdata !== masked) begin
      $error("prdata: expected %0d, got %0d", masked, prdata);
      fail_cnt++;
    end
    psel    <= 1'b0;
    penable <= 1'b0;
    case (idx)
      REG_MOTOR_MIN:     cfg_mmin    = masked[11:0];
      REG_MOTOR_MAX:     cfg_mmax    = masked[11:0];
      REG_MOTOR_NEUTRAL: cfg_neutral = masked[11:0];
      REG_SERVO_MIN:     cfg_smin    = masked[11:0];
      REG_SERVO_MAX:     cfg_smax    = masked[11:0];
      REG_SILENCE_LIMIT: cfg_silence = masked[15:0];
      REG_MOTOR_BASE:    cfg_mbase   = masked[3:0];
      REG_SERVO_BASE:    cfg_sbase   = masked[3:0];
      default: ;
    endcase
  endtask

  task automatic wait_drained();
    do @(negedge clk_i);
    while (cmd_q.size() != 0 || in_valid_i || guard_result_q.size() != 0);
    repeat (6) @(negedge clk_i);
  endtask

  // command driver
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      src_gap    <= 0;
    end else if (!in_valid_i || !in_stall_o) begin
      if (src_gap != 0) begin
        src_gap    <= src_gap - 1;
        in_valid_i <= 1'b0;
      end else if (cmd_q.size() != 0) begin
        in_item_i  <= cmd_q.pop_front();
        in_valid_i <= 1'b1;
        src_gap    <= gap_draw(src_idle_on);
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // result sink back-pressure, stalled for a drawn number of cycles after each transfer
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
      sink_gap    <= 0;
    end else if (out_valid_o && !out_stall_i) begin
      sink_draw    = gap_draw(sink_idle_on);
      sink_gap    <= sink_draw;
      out_stall_i <= (sink_draw != 0);
    end else if (sink_gap != 0) begin
      sink_gap    <= sink_gap - 1;
      out_stall_i <= (sink_gap > 1);
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  // prediction, result check and watchdog
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) guard_predict(in_item_i);
      if (out_valid_o && !out_stall_i) begin
        results_seen++;
        if (guard_result_q.size() == 0) begin
          $error("result transfer with nothing expected: %p", out_item_o);
          fail_cnt++;
        end else begin
          want = guard_result_q.pop_front();
          check_field("is_write", want.is_write, out_item_o.is_write);
          check_field("channel", want.channel, out_item_o.channel);
          check_field("pulse", want.pulse, out_item_o.pulse);
          check_field("accepted", want.accepted, out_item_o.accepted);
          check_field("armed_now", want.armed_now, out_item_o.armed_now);
          check_field("last", want.last, out_item_o.last);
        end
      end
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
          !(in_valid_i || guard_result_q.size() != 0)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
        if (quiet_cycles >= STALL_LIMIT) begin
          $display("Regression FAIL");
          $finish;
        end
      end
    end
  end

  // stimulus sequence
  initial begin
    logic [15:0] nw;
    logic [15:0] vals [8];
    logic [11:0] lo;
    for (int i = 0; i < MOTOR_COUNT; i++) motor_pw[i] = RST_MOTOR_NEUTRAL;
    for (int i = 0; i < SERVO_COUNT; i++) servo_pw[i] = RST_SERVO_PULSE;
    for (int i = 0; i < 8; i++) func_cnt[i] = 0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // directed commands at the reset limits
    nw = {4'h0, cfg_neutral};
    push_cmd(plain_cmd(FUNC_EMIT, 16'd0, 16'd0, 32'd0));
    push_cmd(plain_cmd(FUNC_SPARE_FIRST, 16'hffff, 16'hffff, 32'hffff_ffff));
    push_cmd(override_cmd(nw, MOTOR_COUNT, nw, 32'd100));
    push_cmd(override_cmd(nw, 3, 16'd1600, 32'd120));
    push_cmd(plain_cmd(FUNC_ARM, 16'd0, 16'd1, 32'd0));
    push_cmd(override_cmd(16'd1900, MOTOR_COUNT, 16'd1900, 32'd200));
    push_cmd(override_cmd(16'd1100, 0, 16'd1099, 32'd210));
    push_cmd(override_cmd(16'd1100, 5, 16'hffff, 32'd220));
    push_cmd(override_cmd(16'd1100, 8, 16'd1901, 32'd230));
    push_cmd(plain_cmd(FUNC_EMIT, 16'd0, 16'd0, 32'd0));
    push_cmd(plain_cmd(FUNC_SET_SERVO, 16'd1100, 16'd0, 32'd0));
    push_cmd(plain_cmd(FUNC_SET_SERVO, 16'd1900, 16'd3, 32'd0));
    push_cmd(plain_cmd(FUNC_SET_SERVO, 16'd1500, 16'd4, 32'd0));
    push_cmd(plain_cmd(FUNC_SET_SERVO, 16'd1500, 16'h8000, 32'd0));
    push_cmd(plain_cmd(FUNC_SET_SERVO, 16'd1099, 16'd1, 32'd0));
    push_cmd(plain_cmd(FUNC_SET_SERVO, 16'hffff, 16'd2, 32'd0));
    push_cmd(plain_cmd(FUNC_TICK, 16'd0, 16'd0, 32'd250));
    push_cmd(plain_cmd(FUNC_TICK, 16'd0, 16'd0, 32'd2000));
    push_cmd(plain_cmd(FUNC_TICK, 16'd0, 16'd0, 32'd3500));
    push_cmd(override_cmd(16'd1300, MOTOR_COUNT, 16'd1300, 32'hffff_ffff));
    push_cmd(plain_cmd(FUNC_TICK, 16'd0, 16'd0, 32'd0));
    push_cmd(plain_cmd(FUNC_ARM, 16'd0, 16'h7fff, 32'd0));
    push_cmd(plain_cmd(FUNC_ARM, 16'd0, 16'd0, 32'd0));
    push_cmd(plain_cmd(FUNC_ARM, 16'd0, 16'd5, 32'd0));
    push_cmd(plain_cmd(FUNC_ARM, 16'd0, 16'hffff, 32'd0));
    wait_drained();

    // random phases, each under its own register setting
    gen_armed = 1'b0;
    gen_now   = 32'd5000;
    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0: vals = '{RST_MOTOR_MIN, RST_MOTOR_MAX, RST_MOTOR_NEUTRAL, RST_SERVO_MIN,
                    RST_SERVO_MAX, RST_SILENCE_LIMIT, RST_MOTOR_BASE, RST_SERVO_BASE};
        // widest limits, zero neutral and silence, highest channel bases
        1: vals = '{16'd0, 16'd4095, 16'd0, 16'd0, 16'd4095, 16'd0, 16'd15, 16'd15};
        // crossed limits reject every width
        2: vals = '{16'd4095, 16'd0, 16'd4095, 16'd4095, 16'd0, 16'd65535, 16'd0, 16'd0};
        default: begin
          lo = $urandom_range(0, 2000);
          vals[REG_MOTOR_MIN] = lo;
          vals[REG_MOTOR_MAX] = $urandom_range(lo, 4095);
          vals[REG_MOTOR_NEUTRAL] = ($urandom_range(0, 4) != 0) ?
              16'($urandom_range(lo, vals[REG_MOTOR_MAX])) : 16'($urandom_range(0, 4095));
          lo = $urandom_range(0, 2000);
          vals[REG_SERVO_MIN] = lo;
          vals[REG_SERVO_MAX] = $urandom_range(lo, 4095);
          vals[REG_SILENCE_LIMIT] = $urandom_range(0, 3000);
          vals[REG_MOTOR_BASE] = $urandom_range(0, 15);
          vals[REG_SERVO_BASE] = $urandom_range(0, 15);
        end
      endcase
      for (int r = 0; r < 8; r++) cfg_write(reg_idx_e'(r), vals[r]);
      settings_cnt++;
      @(negedge clk_i);
      // two chunks with a full drain between them
      for (int c = 0; c < 2; c++) begin
        src_idle_on  = (p == 0 && c == 0) ? 1'b0 : ($urandom_range(0, 3) != 0);
        sink_idle_on = (p == 0 && c == 0) ? 1'b0 : ($urandom_range(0, 3) != 0);
        for (int n = 0; n < CHUNK_ITEMS; n++) push_random_cmd();
        wait_drained();
      end
    end

    repeat (30) @(negedge clk_i);
    $display("covered %0d commands: %0d override, %0d arm/disarm, %0d servo, %0d tick, %0d emit",
             func_cnt[FUNC_OVERRIDE] + func_cnt[FUNC_ARM] + func_cnt[FUNC_SET_SERVO] +
             func_cnt[FUNC_TICK] + func_cnt[FUNC_EMIT] + func_cnt[5] + func_cnt[6] +
             func_cnt[7], func_cnt[FUNC_OVERRIDE], func_cnt[FUNC_ARM],
             func_cnt[FUNC_SET_SERVO], func_cnt[FUNC_TICK], func_cnt[FUNC_EMIT]);
    $display("%0d results checked across %0d register settings, %0d errors",
             results_seen, settings_cnt, fail_cnt);
    if (fail_cnt == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
`default_nettype wire
